/* src/mvt_pkg.sv */
package mvt_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_EXEC = 3'b100
  } state_e;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountWidth = 7;

  // cells per partial match count
  localparam int unsigned GroupSize = 8;

  typedef struct packed {
    logic                  add_en;
    logic                  rm_en;
    logic [ValueWidth-1:0] value;
  } cell_ctl_t;

endpackage

/* src/mvt_cell.sv */
module mvt_cell import mvt_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7
) (
  input  logic                  clk_i,
  input  cell_ctl_t             ctl_i,
  input  logic [CW-1:0]         fill_i,
  input  logic [ValueWidth-1:0] next_entry_i,
  input  logic                  hit_i,
  output logic [ValueWidth-1:0] entry_o,
  output logic                  match_o,
  output logic                  hit_o
);

  logic [ValueWidth-1:0] entry_q;
  logic                  match_q;
  logic                  live;

  assign live    = CW'(IDX) < fill_i;
  assign match_o = live && (entry_q == ctl_i.value);
  // set at or after the first matching cell: these cells close the gap on a remove
  assign hit_o   = hit_i | match_q;
  assign entry_o = entry_q;

  always_ff @(posedge clk_i) begin
    match_q <= match_o;
    if (ctl_i.rm_en && hit_o) begin
      entry_q <= next_entry_i;
    end else if (ctl_i.add_en && (fill_i == CW'(IDX))) begin
      entry_q <= ctl_i.value;
    end
  end

endmodule

/* src/mvt_popcount.sv */
module mvt_popcount import mvt_pkg::*; #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned CW       = 7
) (
  input  logic                clk_i,
  input  logic [CAPACITY-1:0] match_i,
  output logic [CW-1:0]       total_o
);

  localparam int unsigned NG = (CAPACITY + GroupSize - 1) / GroupSize;
  localparam int unsigned PW = NG * GroupSize;
  localparam int unsigned GW = $clog2(GroupSize + 1);

  logic [PW-1:0] pad;
  logic [GW-1:0] grp_d [NG];
  logic [GW-1:0] grp_q [NG];

  assign pad = PW'(match_i);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GroupSize; k++) begin
        grp_d[g] = grp_d[g] + GW'(pad[g*GroupSize+k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  always_comb begin
    total_o = '0;
    for (int g = 0; g < NG; g++) begin
      total_o = total_o + CW'(grp_q[g]);
    end
  end

endmodule

/* src/multiset_value_table.sv */
// Multiset of signed 32-bit values held in a row of CAPACITY cells.
// Request channel: in_valid_i / in_stall_o with op_i (add, remove, query)
// and value_i. Result channel: out_valid_o / out_stall_i with ok_o,
// occurrences_o, element_count_o and is_empty_o; one result per request.
// Each request has a compare cycle in which every cell checks
// its entry against the value and partial match counts of 8 cells are
// registered, then an execute cycle that sums the partial counts, updates
// the fill level and writes or compacts the cells. The result is registered
// at the end of the execute cycle; a new request is accepted in the execute cycle,
// so the next request can be taken while the last one is executing.
// A remove shifts every entry after the first match down by one cell.
// The result sits in an output register; while it is stalled the next
// request is still accepted and compared, and its execute cycle waits
// until the output register is free.
// Reset empties the table (fill level zero) and drops any pending result;
// no clearing pass runs, so requests are taken right after reset.
// Counts wider than 7 bits (CAPACITY above 127) are reported modulo 128.
module multiset_value_table import mvt_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   op_i,
  input  logic signed [ValueWidth-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         ok_o,
  output logic [CountWidth-1:0]        occurrences_o,
  output logic [CountWidth-1:0]        element_count_o,
  output logic                         is_empty_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = CW + CountWidth;

  state_e state_q, state_d;

  logic [1:0]            op_q;
  logic [ValueWidth-1:0] value_q;
  logic [CW-1:0]         fill_q, fill_d;
  logic                  out_valid_q;
  logic                  ok_q;
  logic [CountWidth-1:0] occ_q, cnt_q;
  logic                  empty_q;

  logic                  in_fire, exec_fire, full;
  logic [CW-1:0]         match_cnt, occ_n;
  logic                  ok_n, found;
  logic [EW-1:0]         occ_ext, fill_ext;
  cell_ctl_t             ctl;

  logic [ValueWidth-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0]   match_w;
  logic [CAPACITY:0]     hit_w;

  assign full      = fill_q == CW'(CAPACITY);
  assign exec_fire = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !((state_q == ST_IDLE) || exec_fire);
  assign in_fire   = in_valid_i && !in_stall_o;
  assign found     = hit_w[CAPACITY];

  assign ctl.value  = value_q;
  assign ctl.add_en = exec_fire && (op_q == OP_ADD) && !full;
  assign ctl.rm_en  = exec_fire && (op_q == OP_REMOVE);

  assign hit_w[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ValueWidth-1:0] nxt;
    if (i == CAPACITY - 1) begin : g_last
      assign nxt = entry_w[i];
    end else begin : g_mid
      assign nxt = entry_w[i+1];
    end
    mvt_cell #(
      .IDX(i),
      .CW (CW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .fill_i      (fill_q),
      .next_entry_i(nxt),
      .hit_i       (hit_w[i]),
      .entry_o     (entry_w[i]),
      .match_o     (match_w[i]),
      .hit_o       (hit_w[i+1])
    );
  end

  mvt_popcount #(
    .CAPACITY(CAPACITY),
    .CW      (CW)
  ) u_popcount (
    .clk_i  (clk_i),
    .match_i(match_w),
    .total_o(match_cnt)
  );

  // match_cnt counts the contents before this request is applied
  always_comb begin
    ok_n   = 1'b0;
    occ_n  = match_cnt;
    fill_d = fill_q;
    case (op_e'(op_q))
      OP_ADD: begin
        ok_n = !full;
        if (!full) begin
          occ_n  = match_cnt + CW'(1);
          fill_d = fill_q + CW'(1);
        end
      end
      OP_REMOVE: begin
        ok_n = found;
        if (found) begin
          occ_n  = match_cnt - CW'(1);
          fill_d = fill_q - CW'(1);
        end
      end
      OP_QUERY: begin
        ok_n = 1'b1;
      end
      default: begin
        ok_n = 1'b0;
      end
    endcase
  end

  assign occ_ext  = EW'(occ_n);
  assign fill_ext = EW'(fill_d);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_CMP;
      end
      ST_CMP: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (in_fire) begin
          state_d = ST_CMP;
        end else if (exec_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_fire) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= op_i;
      value_q <= value_i;
    end
    if (exec_fire) begin
      ok_q    <= ok_n;
      occ_q   <= occ_ext[CountWidth-1:0];
      cnt_q   <= fill_ext[CountWidth-1:0];
      empty_q <= fill_d == '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = ok_q;
  assign occurrences_o   = occ_q;
  assign element_count_o = cnt_q;
  assign is_empty_o      = empty_q;

endmodule

/* src/mvt_checker.sv */
module mvt_checker import mvt_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         ok_o,
  input logic [CountWidth-1:0]        occurrences_o,
  input logic [CountWidth-1:0]        element_count_o,
  input logic                         is_empty_o
);

  localparam bit Exact = CAPACITY < 128;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ok_o) &&
      $stable(occurrences_o) && $stable(element_count_o) && $stable(is_empty_o))
    else $error("stalled result changed");

  // every request needs a compare cycle before the next one is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted during compare cycle");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && Exact |-> is_empty_o == (element_count_o == '0))
    else $error("empty flag disagrees with element count");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && Exact |-> occurrences_o <= element_count_o)
    else $error("more occurrences than elements");

  // a fresh result must be preceded by an accepted request
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 3))
    else $error("result without a preceding request");

endmodule

bind multiset_value_table mvt_checker #(.CAPACITY(CAPACITY)) u_mvt_checker (.*);
